### rtl/tekd_pkg.sv
`default_nettype none

package tekd_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int TICKS_W = 32;
    localparam int MAX_KEYS = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_TERMINAL_TYPE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

    localparam logic [1:0] TT_PC_ANSI = 2'd0;
    localparam logic [1:0] TT_VT100 = 2'd1;
    localparam logic [1:0] TT_VT100_PLUS = 2'd2;
    localparam logic [1:0] TT_VT_UTF8 = 2'd3;

    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 32'd2000000;

    localparam logic [1:0] SEQ_IDLE = 2'd0;
    localparam logic [1:0] SEQ_ESC = 2'd1;
    localparam logic [1:0] SEQ_CSI = 2'd2;
    localparam logic [1:0] SEQ_SS3 = 2'd3;

    localparam logic [1:0] RP_NONE = 2'd0;
    localparam logic [1:0] RP_ESC_R = 2'd1;
    localparam logic [1:0] RP_ESC_R_ESC_R = 2'd2;

    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [15:0] CH_ESC = 16'h001B;
    localparam logic [15:0] CH_DEL = 16'h007F;
    localparam logic [15:0] CH_LBRACKET = 16'h005B;
    localparam logic [15:0] CH_UPPER_O = 16'h004F;
    localparam logic [15:0] CH_UPPER_R = 16'h0052;
    localparam logic [15:0] CH_LOWER_R = 16'h0072;

    localparam logic [4:0] SC_NONE = 5'd0;
    localparam logic [4:0] SC_DELETE = 5'd8;
    localparam logic [4:0] SC_ESC = 5'd23;

    typedef struct packed {
        logic        func;
        logic [15:0] char_code;
    } item_t;

    typedef struct packed {
        logic [4:0]  scan_code;
        logic [15:0] unicode_char;
        logic        reset_request;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [4:0]  scan_code;
        logic [15:0] unicode_char;
        logic        reset_request;
    } key_t;

    typedef struct packed {
        logic [1:0]         terminal_type;
        logic [TICKS_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        key_t [MAX_KEYS-1:0] keys;
        logic [1:0]          count;
    } group_t;

    function automatic logic [4:0] lookup_esc(input logic [1:0] tt, input logic [15:0] c);
        logic [4:0] scan;
        scan = SC_NONE;
        if (tt == TT_VT100_PLUS || tt == TT_VT_UTF8) begin
            if (c inside {[16'h0031:16'h0039]}) begin
                scan = 5'd10 + {1'b0, c[3:0]};
            end
            else begin
                case (c)
                    16'h0030: scan = 5'd20;
                    16'h0068: scan = 5'd5;
                    16'h006B: scan = 5'd6;
                    16'h002B: scan = 5'd7;
                    16'h002D: scan = 5'd8;
                    16'h002F: scan = 5'd10;
                    16'h003F: scan = 5'd9;
                    default: scan = SC_NONE;
                endcase
            end
        end
        return scan;
    endfunction

    function automatic logic [4:0] lookup_ss3(input logic [1:0] tt, input logic [15:0] c);
        logic [4:0] scan;
        scan = SC_NONE;
        if (tt == TT_VT100) begin
            case (c)
                16'h0050: scan = 5'd11;
                16'h0051: scan = 5'd12;
                16'h0077: scan = 5'd13;
                16'h0078: scan = 5'd14;
                16'h0074: scan = 5'd15;
                16'h0075: scan = 5'd16;
                16'h0071: scan = 5'd17;
                16'h0072: scan = 5'd18;
                16'h0070: scan = 5'd19;
                16'h004D: scan = 5'd20;
                default: scan = SC_NONE;
            endcase
        end
        return scan;
    endfunction

    function automatic logic [4:0] lookup_csi(input logic [1:0] tt, input logic [15:0] c);
        logic       pc;
        logic       vt;
        logic [4:0] scan;
        pc = (tt == TT_PC_ANSI);
        vt = (tt == TT_VT100);
        case (c)
            16'h0041: scan = 5'd1;
            16'h0042: scan = 5'd2;
            16'h0043: scan = 5'd3;
            16'h0044: scan = 5'd4;
            16'h0048: scan = (pc || vt) ? 5'd5 : SC_NONE;
            16'h0046: scan = pc ? 5'd6 : SC_NONE;
            16'h004B: scan = vt ? 5'd6 : SC_NONE;
            16'h004C, 16'h0040: scan = (pc || vt) ? 5'd7 : SC_NONE;
            16'h0058: scan = pc ? 5'd8 : SC_NONE;
            16'h0050: scan = vt ? 5'd8 : (pc ? 5'd14 : SC_NONE);
            16'h0049: scan = pc ? 5'd9 : SC_NONE;
            16'h0056: scan = pc ? 5'd20 : (vt ? 5'd9 : SC_NONE);
            16'h003F: scan = vt ? 5'd9 : SC_NONE;
            16'h0047: scan = pc ? 5'd10 : SC_NONE;
            16'h0055: scan = pc ? 5'd19 : (vt ? 5'd10 : SC_NONE);
            16'h002F: scan = vt ? 5'd10 : SC_NONE;
            16'h004D: scan = pc ? 5'd11 : SC_NONE;
            16'h004E: scan = pc ? 5'd12 : SC_NONE;
            16'h004F: scan = pc ? 5'd13 : SC_NONE;
            16'h0051: scan = pc ? 5'd15 : SC_NONE;
            16'h0052: scan = pc ? 5'd16 : SC_NONE;
            16'h0053: scan = pc ? 5'd17 : SC_NONE;
            16'h0054: scan = pc ? 5'd18 : SC_NONE;
            default: scan = SC_NONE;
        endcase
        return scan;
    endfunction

endpackage

`default_nettype wire

### rtl/tekd_cfg.sv
`default_nettype none

module tekd_cfg
    import tekd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [TICKS_W-1:0]     cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_TERMINAL_TYPE: cfg_next.terminal_type = cfg_data[1:0];
                REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.terminal_type <= TT_PC_ANSI;
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tekd_decode.sv
`default_nettype none

module tekd_decode
    import tekd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  item_valid,
    output logic       item_stall,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    input  wire logic  load_ready,
    output logic       group_load,
    output group_t     group
);

    logic               in_valid_reg;
    logic               in_valid_next;
    item_t              in_item_reg;
    logic [1:0]         seq_reg;
    logic [1:0]         seq_next;
    logic [1:0]         rp_reg;
    logic [1:0]         rp_next;
    logic [TICKS_W-1:0] count_reg;
    logic [TICKS_W-1:0] count_next;
    logic               armed_reg;
    logic               armed_next;
    logic               fire;
    logic [1:0]         n;
    key_t [MAX_KEYS-1:0] keys;
    logic [15:0]        c;
    logic [4:0]         scan;
    logic               keep_rp;
    logic               done;

    assign c = in_item_reg.char_code;

    always_comb
    begin
        seq_next = seq_reg;
        rp_next = rp_reg;
        count_next = count_reg;
        armed_next = armed_reg;
        n = 2'd0;
        keys = '0;
        scan = SC_NONE;
        keep_rp = 1'b0;
        done = 1'b0;

        if (in_item_reg.func == FUNC_TICK) begin
            if (armed_reg) begin
                if (count_reg <= TICKS_W'(1)) begin
                    count_next = '0;
                    rp_next = RP_NONE;
                    if (seq_reg != SEQ_IDLE) begin
                        keys[n] = '{scan_code: SC_ESC, unicode_char: 16'h0000,
                                    reset_request: 1'b0};
                        n = n + 2'd1;
                    end
                    if (seq_reg == SEQ_CSI) begin
                        keys[n] = '{scan_code: SC_NONE, unicode_char: CH_LBRACKET,
                                    reset_request: 1'b0};
                        n = n + 2'd1;
                    end
                    if (seq_reg == SEQ_SS3) begin
                        keys[n] = '{scan_code: SC_NONE, unicode_char: CH_UPPER_O,
                                    reset_request: 1'b0};
                        n = n + 2'd1;
                    end
                    seq_next = SEQ_IDLE;
                    armed_next = 1'b0;
                end
                else begin
                    count_next = count_reg - TICKS_W'(1);
                end
            end
        end
        else begin
            if (seq_reg == SEQ_ESC) begin
                if (c == CH_LBRACKET) begin
                    seq_next = SEQ_CSI;
                    rp_next = RP_NONE;
                    done = 1'b1;
                end
                else if (c == CH_UPPER_O && cfg.terminal_type == TT_VT100) begin
                    seq_next = SEQ_SS3;
                    rp_next = RP_NONE;
                    done = 1'b1;
                end
                else begin
                    scan = lookup_esc(cfg.terminal_type, c);
                    if (c == CH_UPPER_R) begin
                        if (rp_reg == RP_NONE) begin
                            rp_next = RP_ESC_R;
                            keep_rp = 1'b1;
                        end
                        else if (rp_reg == RP_ESC_R_ESC_R) begin
                            seq_next = SEQ_IDLE;
                            rp_next = RP_NONE;
                            armed_next = 1'b0;
                            keys[n] = '{scan_code: SC_NONE, unicode_char: 16'h0000,
                                        reset_request: 1'b1};
                            n = n + 2'd1;
                            done = 1'b1;
                        end
                        scan = SC_NONE;
                    end
                    else if (c == CH_LOWER_R) begin
                        if (rp_reg == RP_ESC_R) begin
                            rp_next = RP_ESC_R_ESC_R;
                            keep_rp = 1'b1;
                        end
                        scan = SC_NONE;
                    end
                    if (!done) begin
                        if (!keep_rp) begin
                            rp_next = RP_NONE;
                        end
                        if (scan != SC_NONE) begin
                            seq_next = SEQ_IDLE;
                            armed_next = 1'b0;
                            keys[n] = '{scan_code: scan, unicode_char: 16'h0000,
                                        reset_request: 1'b0};
                            n = n + 2'd1;
                            done = 1'b1;
                        end
                        else begin
                            keys[n] = '{scan_code: SC_ESC, unicode_char: 16'h0000,
                                        reset_request: 1'b0};
                            n = n + 2'd1;
                            seq_next = SEQ_IDLE;
                            armed_next = 1'b0;
                        end
                    end
                end
            end
            else if (seq_reg == SEQ_CSI || seq_reg == SEQ_SS3) begin
                rp_next = RP_NONE;
                scan = (seq_reg == SEQ_CSI) ? lookup_csi(cfg.terminal_type, c)
                                            : lookup_ss3(cfg.terminal_type, c);
                if (scan != SC_NONE) begin
                    seq_next = SEQ_IDLE;
                    armed_next = 1'b0;
                    keys[n] = '{scan_code: scan, unicode_char: 16'h0000,
                                reset_request: 1'b0};
                    n = n + 2'd1;
                    done = 1'b1;
                end
                else begin
                    keys[n] = '{scan_code: SC_ESC, unicode_char: 16'h0000,
                                reset_request: 1'b0};
                    n = n + 2'd1;
                    keys[n] = '{scan_code: SC_NONE,
                                unicode_char: (seq_reg == SEQ_CSI) ? CH_LBRACKET : CH_UPPER_O,
                                reset_request: 1'b0};
                    n = n + 2'd1;
                    seq_next = SEQ_IDLE;
                    armed_next = 1'b0;
                end
            end

            if (!done) begin
                if (c == CH_ESC) begin
                    seq_next = SEQ_ESC;
                end
                if (seq_next != SEQ_IDLE) begin
                    armed_next = 1'b1;
                    count_next = cfg.timeout_ticks;
                end
                else begin
                    if (!keep_rp) begin
                        rp_next = RP_NONE;
                    end
                    if (c == CH_DEL) begin
                        keys[n] = '{scan_code: SC_DELETE, unicode_char: 16'h0000,
                                    reset_request: 1'b0};
                    end
                    else begin
                        keys[n] = '{scan_code: SC_NONE, unicode_char: c,
                                    reset_request: 1'b0};
                    end
                    n = n + 2'd1;
                end
            end
        end
    end

    assign fire = in_valid_reg && (n == 2'd0 || load_ready);
    assign item_stall = in_valid_reg && !fire;
    assign group_load = fire && (n != 2'd0);
    assign group.keys = keys;
    assign group.count = n;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (!item_stall) begin
            in_valid_next = item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall) begin
            in_item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            seq_reg <= SEQ_IDLE;
            rp_reg <= RP_NONE;
            count_reg <= '0;
            armed_reg <= 1'b0;
        end
        else begin
            in_valid_reg <= in_valid_next;
            if (fire) begin
                seq_reg <= seq_next;
                rp_reg <= rp_next;
                count_reg <= count_next;
                armed_reg <= armed_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/tekd_out.sv
`default_nettype none

module tekd_out
    import tekd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   group_load,
    input  wire group_t group,
    output logic        load_ready,
    output logic        result_valid,
    input  wire logic   result_stall,
    output result_t     result
);

    logic                group_valid_reg;
    logic                group_valid_next;
    logic [1:0]          idx_reg;
    logic [1:0]          idx_next;
    logic [1:0]          count_reg;
    key_t [MAX_KEYS-1:0] keys_reg;
    logic                take;
    logic                last_beat;

    assign take = group_valid_reg && !result_stall;
    assign last_beat = (idx_reg == count_reg - 2'd1);
    assign load_ready = !group_valid_reg || (take && last_beat);

    assign result_valid = group_valid_reg;
    assign result.scan_code = keys_reg[idx_reg].scan_code;
    assign result.unicode_char = keys_reg[idx_reg].unicode_char;
    assign result.reset_request = keys_reg[idx_reg].reset_request;
    assign result.last = last_beat;

    always_comb
    begin
        group_valid_next = group_valid_reg;
        idx_next = idx_reg;
        if (group_load) begin
            group_valid_next = 1'b1;
            idx_next = 2'd0;
        end
        else if (take) begin
            if (last_beat) begin
                group_valid_next = 1'b0;
            end
            else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (group_load) begin
            keys_reg <= group.keys;
            count_reg <= group.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            group_valid_reg <= 1'b0;
            idx_reg <= 2'd0;
        end
        else begin
            group_valid_reg <= group_valid_next;
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

### rtl/terminal_escape_key_decoder.sv
// Channel   Direction  Handshake           Beat contents
// item      in         item_valid/stall    func, char_code
// result    out        result_valid/stall  scan_code, unicode_char, reset_request, last
// cfg       in         cfg_valid/ready     cfg_index, cfg_data
//
// An accepted item is decoded in the cycle after it is taken and its keys land in a
// result register, from which the first result beat is offered.
// Items giving at most one key sustain one per cycle while result_stall is low; an item
// giving several keys holds the result register until they leave, one beat per unstalled cycle.
// Reset clears the escape state, the timer and all valid flags; nothing needs a sweep.
// A stall on the result side backs up into the input register and then item_stall.

`default_nettype none

module terminal_escape_key_decoder
    import tekd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_stall,
    input  wire item_t                  item,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output result_t                     result,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [TICKS_W-1:0]     cfg_data
);

    cfg_t   cfg;
    logic   load_ready;
    logic   group_load;
    group_t group;

    tekd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tekd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg        (cfg),
        .load_ready (load_ready),
        .group_load (group_load),
        .group      (group)
    );

    tekd_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .group_load   (group_load),
        .group        (group),
        .load_ready   (load_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

### dv/terminal_escape_key_decoder_tb.sv
`timescale 1ns / 1ps

module terminal_escape_key_decoder_tb;

    import tekd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD = 80;
    localparam int PHASE_CHARS = 44;

    localparam logic [4:0] SC_UP = 5'd1;
    localparam logic [4:0] SC_DOWN = 5'd2;
    localparam logic [4:0] SC_RIGHT = 5'd3;
    localparam logic [4:0] SC_LEFT = 5'd4;
    localparam logic [4:0] SC_HOME = 5'd5;
    localparam logic [4:0] SC_END = 5'd6;
    localparam logic [4:0] SC_INSERT = 5'd7;
    localparam logic [4:0] SC_PAGE_UP = 5'd9;
    localparam logic [4:0] SC_PAGE_DOWN = 5'd10;
    localparam logic [4:0] SC_F1 = 5'd11;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   item_valid = 1'b0;
    logic                   item_stall;
    item_t                  item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [TICKS_W-1:0]     cfg_data = '0;

    item_t   items_to_send[$];
    result_t keys_due[$];
    logic    item_took = 1'b0;
    logic    calm = 1'b0;
    logic    gaps_off = 1'b0;
    logic    long_hold_req = 1'b0;
    int      gap_left = 0;
    int      stall_left = 0;
    int      hold_left = 0;
    int      bad_beats = 0;
    int      chars_queued = 0;

    logic [1:0]         term_type = TT_PC_ANSI;
    logic [TICKS_W-1:0] tmo_ticks = TIMEOUT_RESET;
    logic [1:0]         seq_st = SEQ_IDLE;
    logic [1:0]         rst_prog = RP_NONE;
    logic [TICKS_W-1:0] tmo_left = '0;
    logic               tmr_armed = 1'b0;

    string csi_finals = "ABCDHFKL@XPIV?GU/MNOQRST";
    string ss3_finals = "PQwxtuqrpM";
    string esc_finals = "1234567890hk+-/?Rr";
    string odd_chars = "[ORr";

    terminal_escape_key_decoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [4:0] esc_scan(logic [15:0] c);
        if (term_type != TT_VT100_PLUS && term_type != TT_VT_UTF8)
            return SC_NONE;
        if (c >= 16'h0031 && c <= 16'h0039)
            return SC_F1 + 5'(c - 16'h0031);
        case (c)
            16'h0030: return SC_F1 + 5'd9;
            16'h0068: return SC_HOME;
            16'h006B: return SC_END;
            16'h002B: return SC_INSERT;
            16'h002D: return SC_DELETE;
            16'h002F: return SC_PAGE_DOWN;
            16'h003F: return SC_PAGE_UP;
            default: return SC_NONE;
        endcase
    endfunction

    function automatic logic [4:0] ss3_scan(logic [15:0] c);
        if (term_type != TT_VT100)
            return SC_NONE;
        case (c)
            16'h0050: return SC_F1;
            16'h0051: return SC_F1 + 5'd1;
            16'h0077: return SC_F1 + 5'd2;
            16'h0078: return SC_F1 + 5'd3;
            16'h0074: return SC_F1 + 5'd4;
            16'h0075: return SC_F1 + 5'd5;
            16'h0071: return SC_F1 + 5'd6;
            16'h0072: return SC_F1 + 5'd7;
            16'h0070: return SC_F1 + 5'd8;
            16'h004D: return SC_F1 + 5'd9;
            default: return SC_NONE;
        endcase
    endfunction

    function automatic logic [4:0] csi_scan(logic [15:0] c);
        logic pc;
        logic vt;
        pc = (term_type == TT_PC_ANSI);
        vt = (term_type == TT_VT100);
        case (c)
            16'h0041: return SC_UP;
            16'h0042: return SC_DOWN;
            16'h0043: return SC_RIGHT;
            16'h0044: return SC_LEFT;
            16'h0048: return (pc || vt) ? SC_HOME : SC_NONE;
            16'h0046: return pc ? SC_END : SC_NONE;
            16'h004B: return vt ? SC_END : SC_NONE;
            16'h004C, 16'h0040: return (pc || vt) ? SC_INSERT : SC_NONE;
            16'h0058: return pc ? SC_DELETE : SC_NONE;
            16'h0050: return vt ? SC_DELETE : (pc ? SC_F1 + 5'd3 : SC_NONE);
            16'h0049: return pc ? SC_PAGE_UP : SC_NONE;
            16'h0056: return pc ? SC_F1 + 5'd9 : (vt ? SC_PAGE_UP : SC_NONE);
            16'h003F: return vt ? SC_PAGE_UP : SC_NONE;
            16'h0047: return pc ? SC_PAGE_DOWN : SC_NONE;
            16'h0055: return pc ? SC_F1 + 5'd8 : (vt ? SC_PAGE_DOWN : SC_NONE);
            16'h002F: return vt ? SC_PAGE_DOWN : SC_NONE;
            16'h004D: return pc ? SC_F1 : SC_NONE;
            16'h004E: return pc ? SC_F1 + 5'd1 : SC_NONE;
            16'h004F: return pc ? SC_F1 + 5'd2 : SC_NONE;
            16'h0051: return pc ? SC_F1 + 5'd4 : SC_NONE;
            16'h0052: return pc ? SC_F1 + 5'd5 : SC_NONE;
            16'h0053: return pc ? SC_F1 + 5'd6 : SC_NONE;
            16'h0054: return pc ? SC_F1 + 5'd7 : SC_NONE;
            default: return SC_NONE;
        endcase
    endfunction

    task automatic add_key(logic [4:0] sc, logic [15:0] ch, logic rq);
        keys_due.push_back(result_t'{scan_code: sc, unicode_char: ch,
                                     reset_request: rq, last: 1'b0});
    endtask

    task automatic flush_pending_keys();
        if (seq_st != SEQ_IDLE)
            add_key(SC_ESC, 16'h0000, 1'b0);
        if (seq_st == SEQ_CSI)
            add_key(SC_NONE, CH_LBRACKET, 1'b0);
        if (seq_st == SEQ_SS3)
            add_key(SC_NONE, CH_UPPER_O, 1'b0);
        seq_st = SEQ_IDLE;
        tmr_armed = 1'b0;
    endtask

    task automatic decode_item(item_t it);
        logic [15:0] c;
        logic [4:0]  sc;
        logic        keep_rp;
        c = it.char_code;
        sc = SC_NONE;
        keep_rp = 1'b0;
        if (it.func == FUNC_TICK)
        begin
            if (tmr_armed)
            begin
                if (tmo_left <= 32'd1)
                begin
                    tmo_left = '0;
                    rst_prog = RP_NONE;
                    flush_pending_keys();
                end
                else
                begin
                    tmo_left = tmo_left - 32'd1;
                end
            end
            return;
        end
        if (seq_st == SEQ_ESC)
        begin
            if (c == CH_LBRACKET || (c == CH_UPPER_O && term_type == TT_VT100))
            begin
                seq_st = (c == CH_LBRACKET) ? SEQ_CSI : SEQ_SS3;
                rst_prog = RP_NONE;
                return;
            end
            sc = esc_scan(c);
            if (c == CH_UPPER_R)
            begin
                sc = SC_NONE;
                if (rst_prog == RP_ESC_R_ESC_R)
                begin
                    seq_st = SEQ_IDLE;
                    rst_prog = RP_NONE;
                    tmr_armed = 1'b0;
                    add_key(SC_NONE, 16'h0000, 1'b1);
                    return;
                end
                if (rst_prog == RP_NONE)
                begin
                    rst_prog = RP_ESC_R;
                    keep_rp = 1'b1;
                end
            end
            else if (c == CH_LOWER_R)
            begin
                sc = SC_NONE;
                if (rst_prog == RP_ESC_R)
                begin
                    rst_prog = RP_ESC_R_ESC_R;
                    keep_rp = 1'b1;
                end
            end
            if (!keep_rp)
                rst_prog = RP_NONE;
        end
        else if (seq_st != SEQ_IDLE)
        begin
            rst_prog = RP_NONE;
            sc = (seq_st == SEQ_CSI) ? csi_scan(c) : ss3_scan(c);
        end
        if (sc != SC_NONE)
        begin
            seq_st = SEQ_IDLE;
            tmr_armed = 1'b0;
            add_key(sc, 16'h0000, 1'b0);
            return;
        end
        if (seq_st != SEQ_IDLE)
            flush_pending_keys();
        if (c == CH_ESC)
            seq_st = SEQ_ESC;
        if (seq_st != SEQ_IDLE)
        begin
            tmr_armed = 1'b1;
            tmo_left = tmo_ticks;
            return;
        end
        if (!keep_rp)
            rst_prog = RP_NONE;
        if (c == CH_DEL)
            add_key(SC_DELETE, 16'h0000, 1'b0);
        else
            add_key(SC_NONE, c, 1'b0);
    endtask

    always @(posedge clk)
    begin : monitor
        result_t want;
        result_t tail;
        int      due_prior;
        if (!rst_n)
        begin
            item_took <= 1'b0;
        end
        else
        begin
            item_took <= item_valid && !item_stall;
            if (item_valid && !item_stall)
            begin
                due_prior = keys_due.size();
                decode_item(item);
                if (keys_due.size() > due_prior)
                begin
                    tail = keys_due.pop_back();
                    tail.last = 1'b1;
                    keys_due.push_back(tail);
                end
            end
            if (result_valid && !result_stall)
            begin
                if (keys_due.size() == 0)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display("%0t unexpected result beat: scan %0d char %h reset %b last %b",
                                 $time, result.scan_code, result.unicode_char,
                                 result.reset_request, result.last);
                end
                else
                begin
                    want = keys_due.pop_front();
                    if (result.scan_code !== want.scan_code
                        || result.unicode_char !== want.unicode_char
                        || result.reset_request !== want.reset_request
                        || result.last !== want.last)
                    begin
                        bad_beats++;
                        if (bad_beats <= 10)
                            $display({"%0t result mismatch: expected scan %0d char %h reset %b",
                                      " last %b, got scan %0d char %h reset %b last %b"},
                                     $time, want.scan_code, want.unicode_char,
                                     want.reset_request, want.last, result.scan_code,
                                     result.unicode_char, result.reset_request, result.last);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin : driver
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || item_took)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (!calm && !gaps_off && $urandom_range(0, 4) == 0)
            begin
                gap_left = $urandom_range(1, 11) - 1;
                item_valid <= 1'b0;
            end
            else if (items_to_send.size() > 0)
            begin
                item <= items_to_send.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : receiver
        if (long_hold_req)
        begin
            hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (!calm && rst_n && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("terminal_escape_key_decoder verification failed");
        $finish;
    end

    task automatic queue_char(logic [15:0] c);
        items_to_send.push_back(item_t'{func: FUNC_CHAR, char_code: c});
        chars_queued++;
    endtask

    task automatic queue_ticks(int n);
        repeat (n) items_to_send.push_back(item_t'{func: FUNC_TICK,
                                                   char_code: 16'($urandom())});
    endtask

    function automatic logic [15:0] pick(string s);
        return {8'h00, s[$urandom_range(0, s.len() - 1)]};
    endfunction

    function automatic logic [15:0] random_char();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 10)
            return 16'($urandom_range(16'h0020, 16'h007E));
        if (roll < 14)
            return 16'($urandom());
        if (roll < 17)
            return 16'($urandom_range(0, 16'h001F));
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return CH_DEL;
            default: return pick(odd_chars);
        endcase
    endfunction

    task automatic queue_random_seq();
        logic [15:0] reset_chars [6];
        int          kind;
        int          n;
        int          broken;
        kind = $urandom_range(0, 99);
        reset_chars = '{CH_ESC, CH_UPPER_R, CH_ESC, CH_LOWER_R, CH_ESC, CH_UPPER_R};
        if (kind < 18)
        begin
            queue_char(random_char());
        end
        else if (kind < 38)
        begin
            queue_char(CH_ESC);
            queue_char(CH_LBRACKET);
            queue_char($urandom_range(0, 4) != 0 ? pick(csi_finals) : random_char());
        end
        else if (kind < 50)
        begin
            queue_char(CH_ESC);
            queue_char(CH_UPPER_O);
            queue_char($urandom_range(0, 4) != 0 ? pick(ss3_finals) : random_char());
        end
        else if (kind < 62)
        begin
            queue_char(CH_ESC);
            queue_char($urandom_range(0, 4) != 0 ? pick(esc_finals) : random_char());
        end
        else if (kind < 70)
        begin
            n = 6;
            broken = -1;
            if ($urandom_range(0, 2) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    n = $urandom_range(1, 5);
                else
                    broken = $urandom_range(0, 5);
            end
            for (int k = 0; k < n; k++)
                queue_char(k == broken ? random_char() : reset_chars[k]);
        end
        else if (kind < 82)
        begin
            queue_char(CH_ESC);
            case ($urandom_range(0, 2))
                0: queue_char(CH_LBRACKET);
                1: queue_char(CH_UPPER_O);
                default: ;
            endcase
            queue_ticks($urandom_range(1, 6));
        end
        else if (kind < 88)
        begin
            queue_char(CH_DEL);
        end
        else if (kind < 94)
        begin
            queue_ticks($urandom_range(1, 3));
        end
        else
        begin
            queue_char(16'($urandom()));
        end
    endtask

    task automatic wait_idle();
        while (items_to_send.size() != 0 || item_valid || keys_due.size() != 0)
            @(posedge clk);
        // Items such as ESC or ticks leave no beat behind, so give the pipeline time to empty.
        repeat (8) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [TICKS_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_TERMINAL_TYPE)
            term_type = data[1:0];
        else if (idx == REG_TIMEOUT_TICKS)
            tmo_ticks = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [31:0] word;
        logic [1:0]  tt;
        logic [31:0] ticks;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_char(16'h0000);
        queue_char(16'hFFFF);
        queue_char(CH_DEL);
        queue_char(16'h0061);
        queue_char(CH_ESC);
        queue_char(CH_LBRACKET);
        queue_char(16'h0041);
        queue_char(CH_ESC);
        queue_char(CH_LBRACKET);
        queue_char(16'h005A);
        queue_char(CH_ESC);
        queue_char(CH_UPPER_R);
        queue_char(CH_ESC);
        queue_char(CH_LOWER_R);
        queue_char(CH_ESC);
        queue_char(CH_UPPER_R);
        queue_char(CH_ESC);
        queue_char(CH_ESC);
        queue_ticks(1);
        wait_idle();
        // The escape is still pending here, so the new type decides how it ends.
        set_reg(REG_TERMINAL_TYPE, {30'd0, TT_VT100});
        queue_char(CH_UPPER_O);
        queue_char(16'h0050);
        wait_idle();
        set_reg(REG_TIMEOUT_TICKS, 32'd0);
        queue_char(CH_ESC);
        queue_ticks(1);
        queue_char(CH_ESC);
        queue_char(CH_LBRACKET);
        queue_ticks(2);

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            case (ph)
                0: begin tt = TT_VT100;       ticks = 32'd3;                  end
                1: begin tt = TT_VT100_PLUS;  ticks = 32'hFFFF_FFFF;          end
                2: begin tt = TT_VT_UTF8;     ticks = 32'd1;                  end
                3: begin tt = TT_PC_ANSI;     ticks = $urandom_range(2, 6);   end
                4: begin tt = TT_VT100;       ticks = 32'd0;                  end
                5: begin tt = 2'($urandom()); ticks = 32'd4;                  end
                6: begin tt = TT_VT100_PLUS;  ticks = $urandom_range(1, 8);   end
                default: begin tt = TT_VT_UTF8; ticks = 32'd2;                end
            endcase
            word = $urandom();
            word[1:0] = tt;
            set_reg(REG_TERMINAL_TYPE, word);
            set_reg(REG_TIMEOUT_TICKS, ticks);
            gaps_off = (ph == 5);
            if (ph == 5)
                long_hold_req = 1'b1;
            if (ph == 7)
                calm = 1'b1;
            chars_queued = 0;
            while (chars_queued < PHASE_CHARS)
                queue_random_seq();
        end

        wait_idle();
        if (keys_due.size() != 0)
            $display("%0d expected key beats never arrived", keys_due.size());
        if (bad_beats == 0 && keys_due.size() == 0)
            $display("terminal_escape_key_decoder verification clean");
        else
            $display("terminal_escape_key_decoder verification failed");
        $finish;
    end

endmodule

### sim.f
rtl/tekd_pkg.sv
rtl/tekd_cfg.sv
rtl/tekd_decode.sv
rtl/tekd_out.sv
rtl/terminal_escape_key_decoder.sv
dv/terminal_escape_key_decoder_tb.sv
